[rtl/core/ufr_pkg.sv]
// ----------------------------------------------------------------------------
// ufr_pkg
// Shared types and constants for the UART frame receiver with XOR check
// ----------------------------------------------------------------------------
package ufr_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned POS_W      = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned OUT_DATA_W = 32;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_HEADER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_HEADER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LED_FUNCTION  = 2'd2;

  // reset values of the registers
  localparam logic [BYTE_W-1:0] FIRST_HEADER_RST  = 8'h55;
  localparam logic [BYTE_W-1:0] SECOND_HEADER_RST = 8'hAA;
  localparam logic [BYTE_W-1:0] LED_FUNCTION_RST  = 8'h06;

  // frame byte positions
  localparam logic [POS_W-1:0] POS_HDR1   = 3'd0;
  localparam logic [POS_W-1:0] POS_HDR2   = 3'd1;
  localparam logic [POS_W-1:0] POS_LENGTH = 3'd2;
  localparam logic [POS_W-1:0] POS_FUNC   = 3'd3;
  localparam logic [POS_W-1:0] POS_DATA1  = 3'd4;
  localparam logic [POS_W-1:0] POS_DATA2  = 3'd5;
  localparam logic [POS_W-1:0] POS_CHECK  = 3'd6;

  typedef struct packed {
    logic [BYTE_W-1:0] first_header;
    logic [BYTE_W-1:0] second_header;
    logic [BYTE_W-1:0] led_function_code;
  } cfg_t;

  typedef struct packed {
    logic              frame_ok;
    logic              led_command;
    logic [BYTE_W-1:0] func_code;
    logic [BYTE_W-1:0] data_first;
    logic [BYTE_W-1:0] data_second;
    logic              led_on;
  } res_t;

  // stream layout, lowest bit first
  function automatic logic [OUT_DATA_W-1:0] pack_res(input res_t r);
    logic [OUT_DATA_W-1:0] d;
    d        = '0;
    d[0]     = r.frame_ok;
    d[1]     = r.led_command;
    d[9:2]   = r.func_code;
    d[17:10] = r.data_first;
    d[25:18] = r.data_second;
    d[26]    = r.led_on;
    return d;
  endfunction

endpackage

[rtl/core/ufr_cfg_regs.sv]
// ----------------------------------------------------------------------------
// ufr_cfg_regs
// Header and LED function code registers behind the write port
// ----------------------------------------------------------------------------
module ufr_cfg_regs import ufr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data,
  output cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_header      <= FIRST_HEADER_RST;
      cfg.second_header     <= SECOND_HEADER_RST;
      cfg.led_function_code <= LED_FUNCTION_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIRST_HEADER:  cfg.first_header      <= cfg_data;
        REG_SECOND_HEADER: cfg.second_header     <= cfg_data;
        REG_LED_FUNCTION:  cfg.led_function_code <= cfg_data;
        default: ; // unmapped index, write ignored
      endcase
    end
  end

endmodule

[rtl/core/ufr_parser.sv]
// ----------------------------------------------------------------------------
// ufr_parser
// Frame position tracking, running XOR and field capture
// ----------------------------------------------------------------------------
module ufr_parser import ufr_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              step,
  input  logic [BYTE_W-1:0] rx,
  output logic              emit,
  output res_t              res
);

  logic [POS_W-1:0]  pos, pos_next;
  logic [BYTE_W-1:0] run_xor, run_xor_next;
  logic [BYTE_W-1:0] func_byte, data1_byte, data2_byte;
  logic              ok;

  always_comb begin
    pos_next     = pos;
    run_xor_next = run_xor ^ rx;
    emit         = 1'b0;
    unique case (pos)
      POS_HDR1: begin
        if (rx == cfg.first_header) begin
          run_xor_next = rx;
          pos_next     = POS_HDR2;
        end else begin
          run_xor_next = '0;
        end
      end
      POS_HDR2: begin
        if (rx == cfg.second_header) begin
          pos_next = POS_LENGTH;
        end else begin
          // not retried as a first header
          run_xor_next = '0;
          pos_next     = POS_HDR1;
        end
      end
      POS_LENGTH: pos_next = POS_FUNC;
      POS_FUNC:   pos_next = POS_DATA1;
      POS_DATA1:  pos_next = POS_DATA2;
      POS_DATA2:  pos_next = POS_CHECK;
      POS_CHECK: begin
        emit         = 1'b1;
        run_xor_next = '0;
        pos_next     = POS_HDR1;
      end
      default: begin
        run_xor_next = '0;
        pos_next     = POS_HDR1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= POS_HDR1;
      run_xor <= '0;
    end else if (step) begin
      pos     <= pos_next;
      run_xor <= run_xor_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && pos == POS_FUNC)  func_byte  <= rx;
    if (step && pos == POS_DATA1) data1_byte <= rx;
    if (step && pos == POS_DATA2) data2_byte <= rx;
  end

  assign ok              = (run_xor == rx);
  assign res.frame_ok    = ok;
  assign res.led_command = ok && (func_byte == cfg.led_function_code);
  assign res.func_code   = func_byte;
  assign res.data_first  = data1_byte;
  assign res.data_second = data2_byte;
  assign res.led_on      = (data2_byte != '0);

endmodule

[rtl/core/ufr_out_reg.sv]
// ----------------------------------------------------------------------------
// ufr_out_reg
// Result register on the master side, holds its word while stalled
// ----------------------------------------------------------------------------
module ufr_out_reg import ufr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  res_t                  res,
  output logic                  free,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  logic                  out_valid;
  logic [OUT_DATA_W-1:0] out_data;

  assign free = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) out_data <= pack_res(res);
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

[rtl/core/uart_frame_receiver_xor_top.sv]
// ----------------------------------------------------------------------------
// uart_frame_receiver_xor_top
// Seven-byte header frame receiver with XOR check and LED command decode
// ----------------------------------------------------------------------------
// result path: the check byte is taken into the input register, then the result
//   word is loaded into the result register, once that is free, and shown on m_tvalid
// throughput: one byte per cycle while the result side can take a word, bounded by the parser step
// reset: synchronous; frame position and running XOR cleared, registers
//   return to 0x55 / 0xAA / 0x06, both word registers emptied
module uart_frame_receiver_xor_top import ufr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [BYTE_W-1:0]     cfg_data,
  // byte input
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [BYTE_W-1:0]     s_tdata,  // [7:0] rx_byte
  // frame results
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata   // [0] frame_ok, [1] led_command,
                                          // [9:2] func_code, [17:10] data_first,
                                          // [25:18] data_second, [26] led_on,
                                          // [31:27] zero
);

  cfg_t              cfg;
  res_t              res;
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              out_free;
  logic              step;
  logic              emit;

  ufr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // a held byte moves on whenever the result side can take a word
  assign step     = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) in_byte <= s_tdata;
  end

  ufr_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (step),
    .rx   (in_byte),
    .emit (emit),
    .res  (res)
  );

  ufr_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (step && emit),
    .res      (res),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  a_emit_reaches_output: assert property (@(posedge clk) disable iff (rst)
    (step && emit) |=> m_tvalid)
    else $error("completed frame did not reach the result register");

  a_led_needs_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tdata[1] || m_tdata[0]))
    else $error("led command flagged on a failed frame");

  a_held_byte_kept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !step) |=> (in_valid && $stable(in_byte)))
    else $error("stalled input byte lost or changed");

  a_empty_takes_input: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("input refused with empty input register");

endmodule

[bench/uart_frame_receiver_xor_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_frame_receiver_xor_top_tb
// Drives serial bytes into the frame receiver and scores the frame words.
// Directed frames first, then randomised frames, broken headers and noise
// under several header and LED code settings, against an in-bench parser.
// ----------------------------------------------------------------------------
module uart_frame_receiver_xor_top_tb;
  import ufr_pkg::*;

  localparam int unsigned LIMIT = 400000;
  localparam int unsigned PHASE_BYTES = 325;
  localparam int unsigned SETTLE = 8;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam res_t NONE = '0;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef struct packed {
    byte_t b;
    logic  typed;
    res_t  want;
  } dir_row_t;

  // directed rows; frame words are typed in where they read off at a glance
  localparam dir_row_t DIR_ROWS [24] = '{
    // good led frame at reset values, xor of the first six is 8'hfc
    {8'h55, 1'b0, NONE}, {8'hAA, 1'b0, NONE}, {8'h07, 1'b0, NONE},
    {8'h06, 1'b0, NONE}, {8'h03, 1'b0, NONE}, {8'h01, 1'b0, NONE},
    {8'hFC, 1'b1, {1'b1, 1'b1, 8'h06, 8'h03, 8'h01, 1'b1}},
    // same frame with a bad check byte: still reported, no led command
    {8'h55, 1'b0, NONE}, {8'hAA, 1'b0, NONE}, {8'h07, 1'b0, NONE},
    {8'h06, 1'b0, NONE}, {8'h03, 1'b0, NONE}, {8'h01, 1'b0, NONE},
    {8'h00, 1'b1, {1'b0, 1'b0, 8'h06, 8'h03, 8'h01, 1'b1}},
    // bad second header, which is not taken as a new first header
    {8'h55, 1'b0, NONE}, {8'h55, 1'b0, NONE}, {8'hAA, 1'b0, NONE},
    // extremes: all-ones fields, zero state byte, zero check
    {8'h55, 1'b0, NONE}, {8'hAA, 1'b0, NONE}, {8'hFF, 1'b0, NONE},
    {8'hFF, 1'b0, NONE}, {8'hFF, 1'b0, NONE}, {8'h00, 1'b0, NONE},
    {8'h00, 1'b1, {1'b1, 1'b0, 8'hFF, 8'hFF, 8'h00, 1'b0}}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [BYTE_W-1:0]     cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [BYTE_W-1:0]     s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  uart_frame_receiver_xor_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // parser copy and its registers
  byte_t       first_hdr_q  = FIRST_HEADER_RST;
  byte_t       second_hdr_q = SECOND_HEADER_RST;
  byte_t       led_code_q   = LED_FUNCTION_RST;
  logic [POS_W-1:0] pos_q   = POS_HDR1;
  byte_t       xor_q  = '0;
  byte_t       func_q = '0;
  byte_t       data1_q = '0;
  byte_t       data2_q = '0;

  res_t        pending_frames [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned bytes_fed = 0;
  bit          calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 35);
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    errors++;
    if (errors <= 10)
      $display("mismatch %s: expected %0h, got %0h", what, want, got);
  endtask

  // one byte through the frame parser
  task automatic parse_byte(input byte_t b, output bit has_res, output res_t r);
    has_res = 1'b0;
    r = NONE;
    case (pos_q)
      POS_HDR1: begin
        if (b == first_hdr_q) begin
          xor_q = b;
          pos_q = POS_HDR2;
        end else begin
          xor_q = '0;
        end
      end
      POS_HDR2: begin
        if (b == second_hdr_q) begin
          xor_q = xor_q ^ b;
          pos_q = POS_LENGTH;
        end else begin
          xor_q = '0;
          pos_q = POS_HDR1;
        end
      end
      POS_LENGTH: begin
        xor_q = xor_q ^ b;
        pos_q = POS_FUNC;
      end
      POS_FUNC: begin
        func_q = b;
        xor_q = xor_q ^ b;
        pos_q = POS_DATA1;
      end
      POS_DATA1: begin
        data1_q = b;
        xor_q = xor_q ^ b;
        pos_q = POS_DATA2;
      end
      POS_DATA2: begin
        data2_q = b;
        xor_q = xor_q ^ b;
        pos_q = POS_CHECK;
      end
      POS_CHECK: begin
        r.frame_ok    = (xor_q == b);
        r.led_command = r.frame_ok && (func_q == led_code_q);
        r.func_code   = func_q;
        r.data_first  = data1_q;
        r.data_second = data2_q;
        r.led_on      = (data2_q != '0);
        has_res = 1'b1;
        pos_q = POS_HDR1;
        xor_q = '0;
      end
      default: begin
        pos_q = POS_HDR1;
        xor_q = '0;
      end
    endcase
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input byte_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_FIRST_HEADER:  first_hdr_q  = val;
      REG_SECOND_HEADER: second_hdr_q = val;
      REG_LED_FUNCTION:  led_code_q   = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(input byte_t hdr1, input byte_t hdr2, input byte_t led);
    write_reg(REG_FIRST_HEADER, hdr1);
    write_reg(REG_SECOND_HEADER, hdr2);
    write_reg(REG_LED_FUNCTION, led);
    write_reg(REG_UNUSED, byte_t'($urandom));
  endtask

  task automatic send_byte(input byte_t b, input bit typed, input res_t want);
    bit   has_res;
    res_t r;
    while (take_break()) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_fed++;
    parse_byte(b, has_res, r);
    if (typed)
      pending_frames.push_back(want);
    else if (has_res)
      pending_frames.push_back(r);
  endtask

  // lower valid, wait out every expected word and the pipeline behind it
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_unit();
    byte_t fr [7];
    byte_t b;
    int unsigned roll;
    int unsigned n;
    roll = $urandom_range(99);
    if (roll < 80) begin
      fr[0] = first_hdr_q;
      fr[1] = second_hdr_q;
      fr[2] = byte_t'($urandom);
      fr[3] = $urandom_range(1) ? led_code_q : byte_t'($urandom);
      fr[4] = byte_t'($urandom);
      fr[5] = ($urandom_range(4) == 0) ? 8'h00 : byte_t'($urandom);
      fr[6] = fr[0] ^ fr[1] ^ fr[2] ^ fr[3] ^ fr[4] ^ fr[5];
      if (roll >= 70) fr[6] = fr[6] ^ (8'h01 << $urandom_range(7));
      for (int i = 0; i < 7; i++) send_byte(fr[i], 1'b0, NONE);
    end else if (roll < 88) begin
      // broken header, sometimes a repeated first header
      b = ($urandom_range(1) && first_hdr_q != second_hdr_q) ?
          first_hdr_q : byte_t'($urandom);
      if (b == second_hdr_q) b = b ^ (8'h01 << $urandom_range(7));
      send_byte(first_hdr_q, 1'b0, NONE);
      send_byte(b, 1'b0, NONE);
    end else begin
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) send_byte(byte_t'($urandom), 1'b0, NONE);
    end
  endtask

  task automatic run_phase(input byte_t hdr1, input byte_t hdr2, input byte_t led);
    int unsigned start;
    drain();
    set_regs(hdr1, hdr2, led);
    start = bytes_fed;
    while (bytes_fed - start < PHASE_BYTES) send_unit();
  endtask

  // result side: random back-pressure and scoring
  always @(posedge clk) begin
    res_t want;
    res_t got;
    m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 35);
    if (!rst && m_tvalid && m_tready) begin
      if (pending_frames.size() == 0) begin
        note_mismatch("unexpected word", '0, m_tdata);
      end else begin
        want = pending_frames.pop_front();
        got.frame_ok    = m_tdata[0];
        got.led_command = m_tdata[1];
        got.func_code   = m_tdata[9:2];
        got.data_first  = m_tdata[17:10];
        got.data_second = m_tdata[25:18];
        got.led_on      = m_tdata[26];
        if (got.frame_ok !== want.frame_ok)
          note_mismatch("frame_ok", 32'(want.frame_ok), 32'(got.frame_ok));
        if (got.led_command !== want.led_command)
          note_mismatch("led_command", 32'(want.led_command), 32'(got.led_command));
        if (got.func_code !== want.func_code)
          note_mismatch("func_code", 32'(want.func_code), 32'(got.func_code));
        if (got.data_first !== want.data_first)
          note_mismatch("data_first", 32'(want.data_first), 32'(got.data_first));
        if (got.data_second !== want.data_second)
          note_mismatch("data_second", 32'(want.data_second), 32'(got.data_second));
        if (got.led_on !== want.led_on)
          note_mismatch("led_on", 32'(want.led_on), 32'(got.led_on));
        if (m_tdata[31:27] !== '0)
          note_mismatch("word padding", '0, 32'(m_tdata[31:27]));
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // unknown index must leave the reset values alone
    write_reg(REG_UNUSED, 8'hFF);
    for (int i = 0; i < 24; i++)
      send_byte(DIR_ROWS[i].b, DIR_ROWS[i].typed, DIR_ROWS[i].want);

    run_phase(8'h00, 8'hFF, 8'h00);
    calm = 1'b1;
    run_phase(8'hFF, 8'h00, 8'hFF);
    calm = 1'b0;
    run_phase(8'h55, 8'h55, byte_t'($urandom));
    run_phase(byte_t'($urandom), byte_t'($urandom), byte_t'($urandom));
    run_phase(FIRST_HEADER_RST, SECOND_HEADER_RST, LED_FUNCTION_RST);
    drain();

    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/ufr_pkg.sv
rtl/core/ufr_cfg_regs.sv
rtl/core/ufr_parser.sv
rtl/core/ufr_out_reg.sv
rtl/core/uart_frame_receiver_xor_top.sv
bench/uart_frame_receiver_xor_top_tb.sv
